>>> hw/rtl/mcbrb_pkg.sv
`default_nettype none

package mcbrb_pkg;

    localparam int CHANNELS          = 4;
    localparam int BYTES_PER_CHANNEL = 256;

    // Widths of the word fields and of the size registers.
    localparam int CMD_W  = 2;
    localparam int CHAN_W = 2;
    localparam int BYTE_W = 8;
    localparam int FILL_W = 2;
    localparam int FREE_W = 9;
    localparam int REG_W  = 9;

    localparam int REG_COUNT = 4;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_W-1:0] SIZE_RESET = REG_W'(256);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W    = $clog2(BYTES_PER_CHANNEL);
    localparam int CNT_W    = (PTR_W + 1 > REG_W) ? PTR_W + 1 : REG_W;
    localparam int STORE_DEPTH = CHANNELS * BYTES_PER_CHANNEL;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [FILL_W-1:0] {
        FILL_EMPTY  = 2'd0,
        FILL_NORMAL = 2'd1,
        FILL_FULL   = 2'd2
    } t_fill;

    // A size of zero acts as one, a size beyond the slice acts as the slice.
    function automatic logic [CNT_W-1:0] eff_size(input logic [REG_W-1:0] size);
        logic [CNT_W-1:0] s;
        s = CNT_W'(size);
        if (s == '0) begin
            s = CNT_W'(1);
        end
        if (s > CNT_W'(BYTES_PER_CHANNEL)) begin
            s = CNT_W'(BYTES_PER_CHANNEL);
        end
        return s;
    endfunction

    // Pointer increment that wraps when it reaches or passes the size.
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] q;
        q = CNT_W'(p) + CNT_W'(1);
        if (q >= size) begin
            q = '0;
        end
        return q[PTR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] free_count(input logic [CNT_W-1:0] size,
                                                    input logic [PTR_W-1:0] w,
                                                    input logic [PTR_W-1:0] r,
                                                    input logic             full);
        logic [CNT_W-1:0] d;
        logic [CNT_W-1:0] f;
        d = '0;
        f = '0;
        if (full) begin
            f = '0;
        end else if (w == r) begin
            f = size;
        end else if (w > r) begin
            d = CNT_W'(w) - CNT_W'(r);
            f = (d >= size) ? '0 : size - d;
        end else begin
            d = CNT_W'(r) - CNT_W'(w);
            f = (d > size) ? size : d;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mcbrb_cmd_if.sv
`default_nettype none

interface mcbrb_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [mcbrb_pkg::CMD_W-1:0]   command;
    logic [mcbrb_pkg::CHAN_W-1:0]  channel;
    logic [mcbrb_pkg::BYTE_W-1:0]  put_byte;

    modport source (output valid, command, channel, put_byte, input ready);
    modport sink   (input valid, command, channel, put_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mcbrb_rsp_if.sv
`default_nettype none

interface mcbrb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mcbrb_pkg::BYTE_W-1:0]  got_byte;
    logic [mcbrb_pkg::FILL_W-1:0]  fill_state;
    logic [mcbrb_pkg::FREE_W-1:0]  free_bytes;
    logic                          took_effect;

    modport source (output valid, got_byte, fill_state, free_bytes, took_effect,
                    input ready);
    modport sink   (input valid, got_byte, fill_state, free_bytes, took_effect,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mcbrb_ram.sv
`default_nettype none

module mcbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/multi_channel_byte_ring_buffer.sv
// Byte FIFOs for several channels in one shared byte store, each channel
// owning a fixed slice and wrapping its pointers at its configured size.
// At most one command word (put, get, query or clear) is taken per clock
// cycle and answered by exactly one response word in the next cycle; the
// response register frees itself in the same cycle in which the sink takes
// it, so the block keeps taking one word per cycle while the sink keeps up.
// A get's byte comes from the store's registered read port. Channel pointers
// and full flags sit in flip-flops and are updated when the command is taken,
// so a following command always sees them. The store itself is not cleared at
// reset; reading a byte that was never put is undefined. The user must write
// size registers only while no command is in flight; the block does not enforce it.
`default_nettype none

module multi_channel_byte_ring_buffer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    mcbrb_cmd_if.sink                           i_cmd,
    mcbrb_rsp_if.source                         o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [mcbrb_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mcbrb_pkg::REG_W-1:0]    i_cfg_wdata
);

    localparam int PTR_W  = mcbrb_pkg::PTR_W;
    localparam int CNT_W  = mcbrb_pkg::CNT_W;
    localparam int ADDR_W = mcbrb_pkg::ADDR_W;

    logic [mcbrb_pkg::REG_W-1:0] r_size [mcbrb_pkg::REG_COUNT];
    logic [PTR_W-1:0]            r_wptr [mcbrb_pkg::CHANNELS];
    logic [PTR_W-1:0]            r_rptr [mcbrb_pkg::CHANNELS];
    logic                        r_full [mcbrb_pkg::CHANNELS];

    logic                          r_valid;
    logic                          r_got_sel;
    logic                          r_was_put;
    mcbrb_pkg::t_fill              r_fill;
    logic [mcbrb_pkg::FREE_W-1:0]  r_free;
    logic                          r_took;

    logic                          accept;
    logic                          ch_ok;
    logic [mcbrb_pkg::CH_IDX_W-1:0] idx;
    mcbrb_pkg::t_cmd               cmd;
    logic [CNT_W-1:0]              size_e;
    logic [PTR_W-1:0]              cur_w;
    logic [PTR_W-1:0]              cur_r;
    logic                          cur_f;
    logic                          cur_empty;
    logic [PTR_W-1:0]              n_w;
    logic [PTR_W-1:0]              n_r;
    logic                          n_f;
    logic                          n_took;
    logic                          do_put;
    logic                          do_get;
    mcbrb_pkg::t_fill              n_fill;
    logic [CNT_W-1:0]              n_free;
    logic [ADDR_W-1:0]             slice_base;
    logic [mcbrb_pkg::BYTE_W-1:0]  ram_rdata;

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_valid || o_rsp.ready;

    always_comb begin
        ch_ok  = (32'(i_cmd.channel) < 32'(mcbrb_pkg::CHANNELS));
        idx    = ch_ok ? i_cmd.channel[mcbrb_pkg::CH_IDX_W-1:0] : '0;
        cmd    = mcbrb_pkg::t_cmd'(i_cmd.command);
        size_e = mcbrb_pkg::eff_size(r_size[i_cmd.channel]);
        cur_w  = r_wptr[idx];
        cur_r  = r_rptr[idx];
        cur_f  = r_full[idx];
        cur_empty = (cur_w == cur_r) && !cur_f;
        n_w    = cur_w;
        n_r    = cur_r;
        n_f    = cur_f;
        n_took = 1'b0;
        do_put = 1'b0;
        do_get = 1'b0;
        unique case (cmd)
            mcbrb_pkg::CMD_PUT: begin
                if (!cur_f) begin
                    n_w    = mcbrb_pkg::advance(cur_w, size_e);
                    n_f    = (n_w == cur_r);
                    n_took = 1'b1;
                    do_put = 1'b1;
                end
            end
            mcbrb_pkg::CMD_GET: begin
                if (!cur_empty) begin
                    n_r    = mcbrb_pkg::advance(cur_r, size_e);
                    n_f    = 1'b0;
                    n_took = 1'b1;
                    do_get = 1'b1;
                end
            end
            mcbrb_pkg::CMD_QUERY: begin
            end
            mcbrb_pkg::CMD_CLEAR: begin
                n_w = '0;
                n_r = '0;
                n_f = 1'b0;
            end
            default: begin
            end
        endcase
        if (n_f) begin
            n_fill = mcbrb_pkg::FILL_FULL;
        end else if (n_w == n_r) begin
            n_fill = mcbrb_pkg::FILL_EMPTY;
        end else begin
            n_fill = mcbrb_pkg::FILL_NORMAL;
        end
        n_free = mcbrb_pkg::free_count(size_e, n_w, n_r, n_f);
        slice_base = ADDR_W'(idx) * ADDR_W'(mcbrb_pkg::BYTES_PER_CHANNEL);
    end

    mcbrb_ram #(
        .WIDTH (mcbrb_pkg::BYTE_W),
        .DEPTH (mcbrb_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && ch_ok && do_put),
        .i_waddr (slice_base + ADDR_W'(cur_w)),
        .i_wdata (i_cmd.put_byte),
        .i_re    (accept && ch_ok && do_get),
        .i_raddr (slice_base + ADDR_W'(cur_r)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mcbrb_pkg::REG_COUNT; i++) begin
                r_size[i] <= mcbrb_pkg::SIZE_RESET;
            end
        end else if (i_cfg_we) begin
            r_size[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < mcbrb_pkg::CHANNELS; c++) begin
                r_wptr[c] <= '0;
                r_rptr[c] <= '0;
                r_full[c] <= 1'b0;
            end
        end else if (accept && ch_ok) begin
            r_wptr[idx] <= n_w;
            r_rptr[idx] <= n_r;
            r_full[idx] <= n_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // An unknown channel answers with an all-zero word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_got_sel <= ch_ok && do_get;
            r_was_put <= ch_ok && do_put;
            r_took    <= ch_ok && n_took;
            r_fill    <= ch_ok ? n_fill : mcbrb_pkg::FILL_EMPTY;
            r_free    <= ch_ok ? n_free[mcbrb_pkg::FREE_W-1:0] : '0;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.got_byte    = r_got_sel ? ram_rdata : '0;
    assign o_rsp.fill_state  = r_fill;
    assign o_rsp.free_bytes  = r_free;
    assign o_rsp.took_effect = r_took;

    generate
        for (genvar c = 0; c < mcbrb_pkg::CHANNELS; c++) begin : g_chk
            a_full_ptrs_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                r_full[c] |-> (r_wptr[c] == r_rptr[c]))
                else $error("channel full flag set with unequal pointers");
        end
    endgenerate

    a_put_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_was_put) |-> (r_fill != mcbrb_pkg::FILL_EMPTY))
        else $error("stored put reported an empty channel");

    a_full_no_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_fill == mcbrb_pkg::FILL_FULL) |-> (r_free == '0))
        else $error("full channel reported free space");

    a_get_empty_noop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == mcbrb_pkg::CMD_GET && cur_empty) |=> !r_took)
        else $error("get on an empty channel took effect");

endmodule

`default_nettype wire
